[hw/rtl/mqrb_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the multi-queue ring buffer.
// No dependencies.
package mqrb_pkg;

    // Sizing
    localparam int NUM_QUEUES    = 8;
    localparam int RING_SLOTS    = 8;
    localparam int ELEMENT_BYTES = 8;

    localparam int QIDX_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int PTR_W  = $clog2(RING_SLOTS);
    localparam int CNT_W  = PTR_W;              // holds RING_SLOTS-1 at most
    localparam int ADDR_W = QIDX_W + PTR_W;
    localparam int DEPTH  = 1 << ADDR_W;

    // Command codes
    localparam logic [2:0] CMD_CREATE = 3'd0;
    localparam logic [2:0] CMD_PUT    = 3'd1;
    localparam logic [2:0] CMD_GET    = 3'd2;
    localparam logic [2:0] CMD_PEEK   = 3'd3;
    localparam logic [2:0] CMD_COUNT  = 3'd4;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_NOTIFY  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_NOTIFY = 1'b1;

    // Status codes
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [3:0]  queue_index;
        logic [63:0] put_data;
        logic [3:0]  put_length;
        logic [3:0]  room;
    } cmd_t;

    typedef struct packed {
        logic        status;
        logic [3:0]  created_index;
        logic [63:0] get_data;
        logic [3:0]  get_length;
        logic [2:0]  element_count;
        logic        full_event;
        logic        empty_event;
    } result_t;

    // Per-queue descriptor
    typedef struct packed {
        logic             allocated;
        logic [PTR_W-1:0] rp;
        logic [PTR_W-1:0] wp;
        logic [CNT_W-1:0] cnt;
    } desc_t;

    typedef struct packed {
        logic              we;
        logic [QIDX_W-1:0] index;
        desc_t             desc;
    } desc_wr_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [63:0]       word;
        logic [3:0]        len;
    } store_wr_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
    } store_clr_t;

    // Keep the low len bytes of a word
    function automatic logic [63:0] byte_mask(input logic [3:0] len);
        logic [63:0] m;
        for (int i = 0; i < 8; i++)
        begin
            m[8*i +: 8] = (len > 4'(i)) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

    // Advance a ring pointer with wrap
    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(RING_SLOTS - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

[hw/rtl/mqrb_store.sv]
`timescale 1ns / 1ps
// Element storage: synchronous word and length memories, one registered read port.
// Depends on mqrb_pkg.
module mqrb_store
    import mqrb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [63:0]       rd_word,
    output logic [3:0]        rd_len,
    input  store_wr_t         wr,
    input  store_clr_t        clr
);

    logic [63:0]      word_mem [DEPTH];
    logic [3:0]       len_mem  [DEPTH];
    logic [DEPTH-1:0] valid_reg;

    logic [63:0] rd_word_reg;
    logic [3:0]  rd_len_reg;
    logic        rd_valid_reg;

    // Memory write port
    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            word_mem[wr.addr] <= wr.word;
            len_mem[wr.addr]  <= wr.len;
        end
    end

    // Registered read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_word_reg <= word_mem[rd_addr];
            rd_len_reg  <= len_mem[rd_addr];
        end
    end

    // Valid bits: a slot never written or taken by a get reads as length zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.we)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            else if (clr.we)
            begin
                valid_reg[clr.addr] <= 1'b0;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_word = rd_word_reg;
    assign rd_len  = rd_valid_reg ? rd_len_reg : 4'd0;

endmodule

[hw/rtl/mqrb_desc.sv]
`timescale 1ns / 1ps
// Queue descriptor table: allocation flag, pointers and count per queue,
// plus the lowest-free-queue search. Depends on mqrb_pkg.
module mqrb_desc
    import mqrb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [QIDX_W-1:0] rd_index,
    output desc_t             rd_desc,
    input  desc_wr_t          wr,
    output logic              free_found,
    output logic [QIDX_W-1:0] free_index
);

    desc_t table_reg [NUM_QUEUES];

    // Descriptor update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                table_reg[i] <= '0;
            end
        end
        else if (wr.we)
        begin
            table_reg[wr.index] <= wr.desc;
        end
    end

    assign rd_desc = table_reg[rd_index];

    // Lowest free queue
    always_comb
    begin
        free_found = 1'b0;
        free_index = '0;
        for (int i = NUM_QUEUES - 1; i >= 0; i--)
        begin
            if (!table_reg[i].allocated)
            begin
                free_found = 1'b1;
                free_index = QIDX_W'(i);
            end
        end
    end

endmodule

[hw/rtl/multi_queue_ring_buffer.sv]
`timescale 1ns / 1ps
// Top level of the multi-queue ring buffer: command sequencing and result register.
// Depends on mqrb_pkg, mqrb_desc and mqrb_store.

// A command is handled as follows: the cycle in which start is taken reads the
// queue descriptor and issues the element memory read at that queue's read
// pointer; the next cycle, with busy high, checks the command, writes the
// descriptor and storage back and registers the result. done is high for one
// cycle with the result and the receiver must take it then; a new command may
// be started in that same cycle, but none is taken while busy is high. Element
// words are undefined until written, but an unwritten slot reads as length
// zero and so returns zero data.
module multi_queue_ring_buffer
    import mqrb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  cmd_t                 command,
    output logic                 done,
    output result_t              result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic                 cfg_data
);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_FINISH = 1'b1;

    logic    state_reg;
    logic    state_next;
    cmd_t    cmd_reg;
    result_t result_reg;
    result_t result_next;
    logic    done_reg;
    logic    full_en_reg;
    logic    empty_en_reg;

    logic              accept;
    logic [QIDX_W-1:0] in_qidx;
    logic [QIDX_W-1:0] cur_qidx;
    logic [QIDX_W-1:0] desc_index;
    desc_t             cur;
    desc_t             upd;
    desc_wr_t          desc_wr;
    logic              free_found;
    logic [QIDX_W-1:0] free_index;
    logic [63:0]       rd_word;
    logic [3:0]        rd_len;
    store_wr_t         st_wr;
    store_clr_t        st_clr;
    logic              usable;

    // Queue index mapped into the table; out-of-range indexes fail anyway
    function automatic logic [QIDX_W-1:0] to_qidx(input logic [3:0] q);
        return ({1'b0, q} < 5'(NUM_QUEUES)) ? QIDX_W'(q) : '0;
    endfunction

    assign busy     = (state_reg == ST_FINISH);
    assign accept   = start && !busy;
    assign in_qidx  = to_qidx(command.queue_index);
    assign cur_qidx = to_qidx(cmd_reg.queue_index);

    // One descriptor read port: incoming command when idle, held command after
    assign desc_index = busy ? cur_qidx : in_qidx;

    mqrb_desc u_desc (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_index   (desc_index),
        .rd_desc    (cur),
        .wr         (desc_wr),
        .free_found (free_found),
        .free_index (free_index)
    );

    // Read the oldest element of the addressed queue as the command is taken
    mqrb_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr ({in_qidx, cur.rp}),
        .rd_word (rd_word),
        .rd_len  (rd_len),
        .wr      (st_wr),
        .clr     (st_clr)
    );

    // Command evaluation and write-back
    always_comb
    begin
        result_next        = '0;
        result_next.status = STATUS_ERR;
        desc_wr            = '0;
        st_wr              = '0;
        st_clr             = '0;
        upd                = cur;
        usable             = ({1'b0, cmd_reg.queue_index} < 5'(NUM_QUEUES)) && cur.allocated;

        unique case (cmd_reg.cmd)
            CMD_CREATE:
            begin
                // A free queue was never used, so its pointers and count are zero
                if (free_found)
                begin
                    desc_wr.we                = 1'b1;
                    desc_wr.index             = free_index;
                    desc_wr.desc              = '0;
                    desc_wr.desc.allocated    = 1'b1;
                    result_next.status        = STATUS_OK;
                    result_next.created_index = 4'(free_index);
                end
            end
            CMD_PUT:
            begin
                if (usable && ({1'b0, cmd_reg.put_length} <= 5'(ELEMENT_BYTES))
                    && (ring_next(cur.wp) != cur.rp))
                begin
                    st_wr.we           = 1'b1;
                    st_wr.addr         = {cur_qidx, cur.wp};
                    st_wr.word         = cmd_reg.put_data & byte_mask(cmd_reg.put_length);
                    st_wr.len          = cmd_reg.put_length;
                    upd.wp             = ring_next(cur.wp);
                    upd.cnt            = cur.cnt + 1'b1;
                    desc_wr.we         = 1'b1;
                    desc_wr.index      = cur_qidx;
                    desc_wr.desc       = upd;
                    result_next.status = STATUS_OK;
                    result_next.full_event =
                        full_en_reg && (upd.cnt == CNT_W'(RING_SLOTS - 1));
                end
            end
            CMD_GET, CMD_PEEK:
            begin
                if (usable && (cmd_reg.room >= rd_len) && (cur.rp != cur.wp))
                begin
                    result_next.status     = STATUS_OK;
                    result_next.get_data   = rd_word & byte_mask(rd_len);
                    result_next.get_length = rd_len;
                    if (cmd_reg.cmd == CMD_GET)
                    begin
                        st_clr.we     = 1'b1;
                        st_clr.addr   = {cur_qidx, cur.rp};
                        upd.rp        = ring_next(cur.rp);
                        upd.cnt       = cur.cnt - 1'b1;
                        desc_wr.we    = 1'b1;
                        desc_wr.index = cur_qidx;
                        desc_wr.desc  = upd;
                        result_next.empty_event = empty_en_reg && (upd.cnt == '0);
                    end
                end
            end
            CMD_COUNT:
            begin
                if (usable)
                begin
                    result_next.status = STATUS_OK;
                end
            end
            default:
            begin
                result_next.status = STATUS_ERR;
            end
        endcase

        // Count after the command for any valid queue command
        if (usable && (cmd_reg.cmd != CMD_CREATE) && (cmd_reg.cmd <= CMD_COUNT))
        begin
            result_next.element_count = 3'(upd.cnt);
        end

        // Write-back only in the finishing cycle
        desc_wr.we = desc_wr.we && busy;
        st_wr.we   = st_wr.we && busy;
        st_clr.we  = st_clr.we && busy;
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= busy;
        end
    end

    // Command and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= command;
        end
        if (busy)
        begin
            result_reg <= result_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_en_reg  <= 1'b0;
            empty_en_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FULL_NOTIFY:  full_en_reg  <= cfg_data;
                CFG_EMPTY_NOTIFY: empty_en_reg <= cfg_data;
                default:          full_en_reg  <= full_en_reg;
            endcase
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

[sim/tb_multi_queue_ring_buffer.sv]
`timescale 1ns / 1ps
// Self-checking testbench for multi_queue_ring_buffer: directed and random commands
// are predicted by a behavioural queue tracker and every result transfer is checked.
// Depends on mqrb_pkg and multi_queue_ring_buffer.
module tb_multi_queue_ring_buffer;
    import mqrb_pkg::*;

    // Command codes the block does not define
    localparam logic [2:0] CMD_BAD_LO = 3'd5;
    localparam logic [2:0] CMD_BAD_HI = 3'd7;

    localparam int     RANDOM_PHASES   = 4;
    localparam int     ITEMS_PER_PHASE = 300;
    localparam int     MIX_SPAN        = 30;
    localparam int     PRINT_CAP       = 100;
    localparam int     SETTLE_CYCLES   = 4;
    localparam longint TIMEOUT_NS      = 2_000_000;

    // Tracks queue contents and holds the results still owed by the block
    class ring_queue_tracker;
        bit          full_notify;
        bit          empty_notify;
        bit          queue_live [NUM_QUEUES];
        int          head_ptr   [NUM_QUEUES];
        int          tail_ptr   [NUM_QUEUES];
        int          fill       [NUM_QUEUES];
        logic [63:0] slot_word  [NUM_QUEUES*RING_SLOTS];
        int          slot_len   [NUM_QUEUES*RING_SLOTS];
        result_t     pending_results [$];
        int          failures;

        function logic [63:0] keep_bytes(logic [63:0] word, int len);
            if (len >= 8)
                return word;
            return word & ((64'd1 << (8 * len)) - 64'd1);
        endfunction

        // Work out the result of one accepted command and update the queues
        function void note_command(cmd_t c);
            result_t r;
            int      q;
            int      slot;
            int      next_tail;
            bit      usable;
            bit      claimed;
            r        = '0;
            r.status = STATUS_ERR;
            q        = c.queue_index;
            usable   = (q < NUM_QUEUES) ? queue_live[q] : 1'b0;
            claimed  = 1'b0;
            if (c.cmd == CMD_CREATE)
            begin
                // lowest free queue wins
                for (int i = 0; i < NUM_QUEUES; i++)
                begin
                    if (!claimed && !queue_live[i])
                    begin
                        queue_live[i]     = 1'b1;
                        r.created_index   = 4'(i);
                        r.element_count   = 3'(fill[i]);
                        r.status          = STATUS_OK;
                        claimed           = 1'b1;
                    end
                end
            end
            else if (c.cmd <= CMD_COUNT && usable)
            begin
                case (c.cmd)
                    CMD_PUT:
                    begin
                        // one slot always stays empty
                        next_tail = (tail_ptr[q] + 1) % RING_SLOTS;
                        if (c.put_length <= ELEMENT_BYTES && next_tail != head_ptr[q])
                        begin
                            slot            = q * RING_SLOTS + tail_ptr[q];
                            slot_word[slot] = keep_bytes(c.put_data, c.put_length);
                            slot_len[slot]  = c.put_length;
                            tail_ptr[q]     = next_tail;
                            fill[q]++;
                            r.full_event    = full_notify && (fill[q] == RING_SLOTS - 1);
                            r.status        = STATUS_OK;
                        end
                    end
                    CMD_GET, CMD_PEEK:
                    begin
                        // room is checked against the head slot, even on an empty ring
                        slot = q * RING_SLOTS + head_ptr[q];
                        if (c.room >= slot_len[slot] && head_ptr[q] != tail_ptr[q])
                        begin
                            r.get_data   = keep_bytes(slot_word[slot], slot_len[slot]);
                            r.get_length = 4'(slot_len[slot]);
                            if (c.cmd == CMD_GET)
                            begin
                                slot_len[slot] = 0;
                                head_ptr[q]    = (head_ptr[q] + 1) % RING_SLOTS;
                                fill[q]--;
                                r.empty_event  = empty_notify && (fill[q] == 0);
                            end
                            r.status = STATUS_OK;
                        end
                    end
                    default:
                        r.status = STATUS_OK;
                endcase
                r.element_count = 3'(fill[q]);
            end
            pending_results.push_back(r);
        endfunction

        task report(string msg);
            failures++;
            if (failures <= PRINT_CAP)
                $display("mismatch %0d at %0t ns: %s", failures, $time, msg);
        endtask

        task compare_field(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                report($sformatf("%s got %h, expected %h", name, got, want));
        endtask

        // Compare one result transfer with the oldest outstanding prediction
        task check_result(result_t got);
            result_t want;
            if (pending_results.size() == 0)
            begin
                report($sformatf("result with nothing outstanding: %h", got));
                return;
            end
            want = pending_results.pop_front();
            compare_field("status", got.status, want.status);
            compare_field("created_index", got.created_index, want.created_index);
            compare_field("get_data", got.get_data, want.get_data);
            compare_field("get_length", got.get_length, want.get_length);
            compare_field("element_count", got.element_count, want.element_count);
            compare_field("full_event", got.full_event, want.full_event);
            compare_field("empty_event", got.empty_event, want.empty_event);
        endtask
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    cmd_t                 command;
    logic                 done;
    result_t              result;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic                 cfg_data;

    ring_queue_tracker    tracker;
    int                   burst_left = 0;

    multi_queue_ring_buffer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .command   (command),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // Result transfers cannot be held off: check each one at its edge
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
            tracker.check_result(result);
    end

    function automatic cmd_t make_cmd(logic [2:0] op, int q, logic [63:0] data, int len,
                                      int room);
        cmd_t c;
        c.cmd         = op;
        c.queue_index = 4'(q);
        c.put_data    = data;
        c.put_length  = 4'(len);
        c.room        = 4'(room);
        return c;
    endfunction

    // Random command; put_pct steers the focus queue towards full or empty
    function automatic cmd_t random_command(int put_pct, int focus);
        cmd_t c;
        int   roll;
        c.put_data = {$urandom, $urandom};
        if ($urandom_range(99) < 85)
            c.put_length = 4'($urandom_range(ELEMENT_BYTES));
        else
            c.put_length = 4'($urandom_range(15, ELEMENT_BYTES + 1));
        if ($urandom_range(99) < 70)
            c.room = 4'($urandom_range(15, ELEMENT_BYTES));
        else
            c.room = 4'($urandom_range(15));
        roll = $urandom_range(99);
        if (roll < 70)
            c.queue_index = 4'(focus);
        else if (roll < 92)
            c.queue_index = 4'($urandom_range(NUM_QUEUES - 1));
        else
            c.queue_index = 4'($urandom_range(15, NUM_QUEUES));
        roll = $urandom_range(99);
        if (roll < put_pct)
            c.cmd = CMD_PUT;
        else
        begin
            roll = $urandom_range(99);
            if (roll < 55)
                c.cmd = CMD_GET;
            else if (roll < 72)
                c.cmd = CMD_PEEK;
            else if (roll < 86)
                c.cmd = CMD_COUNT;
            else if (roll < 94)
                c.cmd = CMD_CREATE;
            else
                c.cmd = 3'($urandom_range(CMD_BAD_HI, CMD_BAD_LO));
        end
        return c;
    endfunction

    // Sender bursts: between bursts, drop start for a random pause
    task automatic pace();
        if (burst_left > 0)
            burst_left--;
        else
        begin
            start <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clk);
            if ($urandom_range(7) == 0)
                burst_left = $urandom_range(80, 30);
            else
                burst_left = $urandom_range(10);
        end
    endtask

    // Hold the command until a transfer happens (start high, busy low)
    task automatic send_command(input cmd_t c);
        pace();
        start   <= 1'b1;
        command <= c;
        do
            @(posedge clk);
        while (busy);
        tracker.note_command(c);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (tracker.pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Both notify registers, on consecutive edges while the block is idle
    task automatic set_notify(input bit full_en, input bit empty_en);
        while (busy)
            @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FULL_NOTIFY;
        cfg_data  <= full_en;
        @(posedge clk);
        cfg_index <= CFG_EMPTY_NOTIFY;
        cfg_data  <= empty_en;
        @(posedge clk);
        cfg_we    <= 1'b0;
        tracker.full_notify  = full_en;
        tracker.empty_notify = empty_en;
    endtask

    initial
    begin
        #(TIMEOUT_NS);
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int put_pct;
        int focus;
        tracker   = new();
        start     <= 1'b0;
        command   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_FULL_NOTIFY;
        cfg_data  <= 1'b0;
        rst_n     <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_notify(1'b1, 1'b1);

        // Unallocated queue and undefined commands
        send_command(make_cmd(CMD_GET, 0, '1, 0, 15));
        send_command(make_cmd(CMD_COUNT, 0, '0, 0, 0));
        send_command(make_cmd(CMD_BAD_LO, 3, '1, 15, 15));
        send_command(make_cmd(CMD_BAD_HI, 15, '1, 15, 15));

        // Claim every queue, then one more with none free
        for (int i = 0; i <= NUM_QUEUES; i++)
            send_command(make_cmd(CMD_CREATE, $urandom_range(15), {$urandom, $urandom},
                                  $urandom_range(15), $urandom_range(15)));

        // Index out of range, oversized put
        send_command(make_cmd(CMD_PUT, 15, '1, 4, 15));
        send_command(make_cmd(CMD_PUT, 0, '1, 15, 15));

        // Fill queue 1 to capacity, then one put too many
        for (int i = 0; i < RING_SLOTS; i++)
            send_command(make_cmd(CMD_PUT, 1,
                                  (i == 1) ? 64'd0 : ((i % 2 == 0) ? '1 : {$urandom, $urandom}),
                                  (i == 0) ? ELEMENT_BYTES : i, 0));

        // Room smaller than the head element, then a peek and a count
        send_command(make_cmd(CMD_GET, 1, '0, 0, 0));
        send_command(make_cmd(CMD_PEEK, 1, '0, 0, 15));
        send_command(make_cmd(CMD_COUNT, 1, '0, 0, 0));

        // Random phases, each under its own notify setting
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            wait_idle();
            set_notify(ph[0], ph[1]);
            put_pct = 50;
            focus   = 0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (n % MIX_SPAN == 0)
                begin
                    put_pct = 20 + 30 * $urandom_range(2);
                    focus   = $urandom_range(NUM_QUEUES - 1);
                end
                send_command(random_command(put_pct, focus));
            end
        end

        wait_idle();
        if (tracker.failures == 0 && tracker.pending_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
